// File: src/double_ended_queue_macros.svh
// assertion helpers used by the queue datapath
`ifndef DOUBLE_ENDED_QUEUE_MACROS_SVH
`define DOUBLE_ENDED_QUEUE_MACROS_SVH

// property that must hold at every clock edge out of reset
`define DQ_ASSERT(lbl, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (prop)) else $error(msg);

// implication into the next cycle, out of reset
`define DQ_ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) else $error(msg);

`endif

// File: src/dq_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package dq_pkg;

	localparam int DEPTH  = 16;
	localparam int IDX_W  = $clog2(DEPTH);
	localparam int CNT_W  = $clog2(DEPTH + 1);
	localparam int SUM_W  = CNT_W + 1;
	localparam int WORD_W = 32;

	typedef enum logic [2:0] {
		REQ_PUSH_FRONT = 3'd0,
		REQ_PUSH_BACK  = 3'd1,
		REQ_POP_FRONT  = 3'd2,
		REQ_POP_BACK   = 3'd3,
		REQ_DUMP_FWD   = 3'd4,
		REQ_DUMP_BWD   = 3'd5
	} req_t;

	typedef enum logic [1:0] {
		ST_OK    = 2'd0,
		ST_EMPTY = 2'd1,
		ST_FULL  = 2'd2
	} st_t;

	typedef enum logic {
		S_IDLE,
		S_FETCH
	} fsm_t;

	// controller to datapath
	typedef struct packed {
		logic push;        // write value at one end
		logic pop;         // read one end and remove it
		logic dump_start;  // first read of a read-out
		logic dump_next;   // following read of a read-out
		logic at_back;     // end for push / pop, direction for read-out
		logic load_imm;    // load result register with an immediate status
		st_t  imm_status;
		logic load_rd;     // load result register from read data
	} dq_cmd_t;

	// datapath to controller
	typedef struct packed {
		logic empty;
		logic full;
		logic out_free;    // result register can take a new result this cycle
		logic rd_last;     // pending read data is the final result of the request
	} dq_stat_t;

	// reduce a sum below 2 * DEPTH into a ring index
	function automatic logic [IDX_W-1:0] ring_wrap(input logic [SUM_W-1:0] x);
		logic [SUM_W-1:0] t;
		t = (x >= SUM_W'(DEPTH)) ? x - SUM_W'(DEPTH) : x;
		return t[IDX_W-1:0];
	endfunction

endpackage

`default_nettype wire

// File: src/dq_ctrl.sv
`timescale 1ns / 1ps
`default_nettype none

module dq_ctrl
	import dq_pkg::*;
(
	input  wire logic       clk,
	input  wire logic       arst_n,
	input  wire logic       req_valid,
	input  wire logic [2:0] req_type,
	output logic            req_stall,
	input  wire dq_stat_t   stat,
	output dq_cmd_t         cmd
);

	fsm_t state_q, state_d;
	req_t req;
	logic take;

	assign req  = req_t'(req_type);
	assign take = (state_q == S_IDLE) && req_valid && stat.out_free;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	// next state
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			S_IDLE: begin
				if (take) begin
					unique case (req)
						REQ_POP_FRONT, REQ_POP_BACK, REQ_DUMP_FWD, REQ_DUMP_BWD: begin
							if (!stat.empty) state_d = S_FETCH;
						end
						default: state_d = S_IDLE;
					endcase
				end
			end
			S_FETCH: begin
				if (stat.out_free && stat.rd_last) state_d = S_IDLE;
			end
			default: state_d = S_IDLE;
		endcase
	end

	// outputs
	always_comb begin
		cmd       = '0;
		req_stall = 1'b1;
		unique case (state_q)
			S_IDLE: begin
				req_stall = !stat.out_free;
				if (take) begin
					unique case (req)
						REQ_PUSH_FRONT, REQ_PUSH_BACK: begin
							cmd.load_imm   = 1'b1;
							cmd.at_back    = (req == REQ_PUSH_BACK);
							cmd.push       = !stat.full;
							cmd.imm_status = stat.full ? ST_FULL : ST_OK;
						end
						REQ_POP_FRONT, REQ_POP_BACK: begin
							cmd.at_back = (req == REQ_POP_BACK);
							if (stat.empty) begin
								cmd.load_imm   = 1'b1;
								cmd.imm_status = ST_EMPTY;
							end else begin
								cmd.pop = 1'b1;
							end
						end
						REQ_DUMP_FWD, REQ_DUMP_BWD: begin
							cmd.at_back = (req == REQ_DUMP_BWD);
							if (stat.empty) begin
								cmd.load_imm   = 1'b1;
								cmd.imm_status = ST_EMPTY;
							end else begin
								cmd.dump_start = 1'b1;
							end
						end
						default: cmd = '0;
					endcase
				end
			end
			S_FETCH: begin
				if (stat.out_free) begin
					cmd.load_rd   = 1'b1;
					cmd.dump_next = !stat.rd_last;
				end
			end
			default: cmd = '0;
		endcase
	end

endmodule

`default_nettype wire

// File: src/dq_datapath.sv
`timescale 1ns / 1ps
`default_nettype none

module dq_datapath
	import dq_pkg::*;
(
	input  wire logic                     clk,
	input  wire logic                     arst_n,
	input  wire dq_cmd_t                  cmd,
	output dq_stat_t                      stat,
	input  wire logic signed [WORD_W-1:0] value,
	output logic                          rsp_valid,
	input  wire logic                     rsp_stall,
	output logic signed [WORD_W-1:0]      word,
	output logic [1:0]                    status,
	output logic                          last
);

`include "double_ended_queue_macros.svh"

	logic [WORD_W-1:0] mem_q [DEPTH];
	logic [WORD_W-1:0] rdata_q;
	logic              rd_last_q;

	logic [IDX_W-1:0]  front_q;
	logic [CNT_W-1:0]  count_q;
	logic [IDX_W-1:0]  idx_q;
	logic              dir_q;

	logic              out_valid_q;
	logic [WORD_W-1:0] word_q;
	st_t               status_q;
	logic              last_q;

	logic              rd_en;
	logic              rd_back;
	logic [IDX_W-1:0]  k;
	logic [IDX_W-1:0]  raddr;
	logic [IDX_W-1:0]  waddr;
	logic [IDX_W-1:0]  front_dec;
	logic              rd_last_d;

	assign rd_en   = cmd.pop || cmd.dump_start || cmd.dump_next;
	assign rd_back = cmd.dump_next ? dir_q : cmd.at_back;
	assign k       = cmd.dump_next ? idx_q : '0;

	assign front_dec = ring_wrap(SUM_W'(front_q) + SUM_W'(DEPTH - 1));

	always_comb begin
		if (rd_back) begin
			raddr = ring_wrap(SUM_W'(front_q) + SUM_W'(count_q) - SUM_W'(1) - SUM_W'(k));
		end else begin
			raddr = ring_wrap(SUM_W'(front_q) + SUM_W'(k));
		end
	end

	assign waddr     = cmd.at_back ? ring_wrap(SUM_W'(front_q) + SUM_W'(count_q)) : front_dec;
	assign rd_last_d = cmd.pop || (CNT_W'(k) + CNT_W'(1) == count_q);

	// ring storage, registered read
	always_ff @(posedge clk) begin
		if (cmd.push) mem_q[waddr] <= value;
		if (rd_en) rdata_q <= mem_q[raddr];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			front_q   <= '0;
			count_q   <= '0;
			idx_q     <= '0;
			dir_q     <= 1'b0;
			rd_last_q <= 1'b0;
		end else begin
			if (cmd.push) begin
				count_q <= count_q + CNT_W'(1);
				if (!cmd.at_back) front_q <= front_dec;
			end else if (cmd.pop) begin
				count_q <= count_q - CNT_W'(1);
				if (!cmd.at_back) front_q <= ring_wrap(SUM_W'(front_q) + SUM_W'(1));
			end
			if (cmd.dump_start) dir_q <= cmd.at_back;
			if (rd_en) begin
				idx_q     <= k + IDX_W'(1);
				rd_last_q <= rd_last_d;
			end
		end
	end

	// result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (cmd.load_imm || cmd.load_rd) begin
			out_valid_q <= 1'b1;
		end else if (!rsp_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load_imm) begin
			word_q   <= '0;
			status_q <= cmd.imm_status;
			last_q   <= 1'b1;
		end else if (cmd.load_rd) begin
			word_q   <= rdata_q;
			status_q <= ST_OK;
			last_q   <= rd_last_q;
		end
	end

	assign stat.empty    = (count_q == '0);
	assign stat.full     = (count_q == CNT_W'(DEPTH));
	assign stat.out_free = !out_valid_q || !rsp_stall;
	assign stat.rd_last  = rd_last_q;

	assign rsp_valid = out_valid_q;
	assign word      = word_q;
	assign status    = status_q;
	assign last      = last_q;

	`DQ_ASSERT(a_count_bound, count_q <= CNT_W'(DEPTH), "entry count above depth")
	`DQ_ASSERT(a_load_free, !(cmd.load_imm || cmd.load_rd) || stat.out_free, "result overwritten")
	`DQ_ASSERT(a_push_room, !cmd.push || !stat.full, "push into full queue")
	`DQ_ASSERT_NEXT(a_pop_count, cmd.pop, count_q == $past(count_q) - CNT_W'(1), "pop count")
	`DQ_ASSERT_NEXT(a_push_count, cmd.push, count_q == $past(count_q) + CNT_W'(1), "push count")

endmodule

`default_nettype wire

// File: src/double_ended_queue.sv
// bounded double-ended queue of signed 32-bit words held in a ring memory
// request channel: req_valid / req_stall with req_type and value; a transfer
// happens on a rising edge with req_valid high and req_stall low
// response channel: rsp_valid / rsp_stall with word, status and last
// push: result (word 0, ok or full) registered at the request transfer, so
//   pushes can run back to back while the result register is free
// pop: the ring is read into a data register, then copied into the result
//   register once that is free; a pop holds off requests until the copy
// read-out: one result per cycle while the result register is free, from the
//   single ring read port, so a queue of n entries holds off requests until
//   all n results are loaded; an empty queue gives one empty-status result at once
// unused request codes are taken and give no result
// req_stall stays high while a pop or read-out is in flight, and also while
//   the result register is full and rsp_stall is high
// a stalled result holds its fields; read-outs simply pause
// reset empties the queue (front index and count cleared) and drops any
//   pending result; ring contents are not cleared and are never read
//   before being pushed
`timescale 1ns / 1ps
`default_nettype none

module double_ended_queue
	import dq_pkg::*;
(
	input  wire logic                     clk,
	input  wire logic                     arst_n,
	input  wire logic                     req_valid,
	output logic                          req_stall,
	input  wire logic [2:0]               req_type,
	input  wire logic signed [WORD_W-1:0] value,
	output logic                          rsp_valid,
	input  wire logic                     rsp_stall,
	output logic signed [WORD_W-1:0]      word,
	output logic [1:0]                    status,
	output logic                          last
);

	// command and status between sequencer and datapath
	dq_cmd_t  cmd;
	dq_stat_t stat;

	// request decode and read-out sequencing
	dq_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.req_valid (req_valid),
		.req_type  (req_type),
		.req_stall (req_stall),
		.stat      (stat),
		.cmd       (cmd)
	);

	// ring memory, front index, entry count and result register
	dq_datapath u_dp (
		.clk       (clk),
		.arst_n    (arst_n),
		.cmd       (cmd),
		.stat      (stat),
		.value     (value),
		.rsp_valid (rsp_valid),
		.rsp_stall (rsp_stall),
		.word      (word),
		.status    (status),
		.last      (last)
	);

endmodule

`default_nettype wire

// File: verif/double_ended_queue_test.sv
`timescale 1ns / 1ps

module double_ended_queue_test;
	import dq_pkg::*;

	localparam int CLK_PERIOD  = 12;
	localparam int RESET_TICKS = 9;
	localparam int HOLD_CYCLES = 80;   // long receiver hold-off, fills the result path
	localparam int TAIL_CYCLES = 40;   // longer than a full read-out
	localparam int PHASE_ITEMS = 80;
	localparam int BURST_ITEMS = 20;

	// request codes the block takes and drops without a result
	localparam logic [2:0] REQ_SPARE_A = 3'd6;
	localparam logic [2:0] REQ_SPARE_B = 3'd7;

	typedef enum int {MIX_FILL, MIX_DRAIN, MIX_EVEN} mix_t;

	// one result as the block should present it
	typedef struct {
		logic signed [WORD_W-1:0] word;
		st_t                      status;
		logic                     last;
	} deque_result_t;

	// shadow copy of the ring plus the results still owed by the block
	class deque_shadow;
		logic signed [WORD_W-1:0] ring [DEPTH];
		int front_idx = 0;
		int held = 0;
		deque_result_t owed[$];
		int mismatches = 0;

		function void owe(input logic signed [WORD_W-1:0] w, input st_t s, input logic l);
			deque_result_t r;
			r.word   = w;
			r.status = s;
			r.last   = l;
			owed.push_back(r);
		endfunction

		// predict the results of one accepted request
		function void note_request(input logic [2:0] kind,
				input logic signed [WORD_W-1:0] v);
			int pos;
			case (kind)
				REQ_PUSH_FRONT, REQ_PUSH_BACK: begin
					if (held >= DEPTH) begin
						owe('0, ST_FULL, 1'b1);
					end else begin
						if (kind == REQ_PUSH_FRONT) begin
							front_idx = (front_idx + DEPTH - 1) % DEPTH;
							ring[front_idx] = v;
						end else begin
							ring[(front_idx + held) % DEPTH] = v;
						end
						held++;
						owe('0, ST_OK, 1'b1);
					end
				end
				REQ_POP_FRONT, REQ_POP_BACK: begin
					if (held == 0) begin
						owe('0, ST_EMPTY, 1'b1);
					end else begin
						if (kind == REQ_POP_FRONT) begin
							pos = front_idx;
							front_idx = (front_idx + 1) % DEPTH;
						end else begin
							pos = (front_idx + held - 1) % DEPTH;
						end
						held--;
						owe(ring[pos], ST_OK, 1'b1);
					end
				end
				REQ_DUMP_FWD, REQ_DUMP_BWD: begin
					if (held == 0) begin
						owe('0, ST_EMPTY, 1'b1);
					end else begin
						for (int i = 0; i < held; i++) begin
							if (kind == REQ_DUMP_FWD)
								pos = (front_idx + i) % DEPTH;
							else
								pos = (front_idx + held - 1 - i) % DEPTH;
							owe(ring[pos], ST_OK, (i + 1 == held));
						end
					end
				end
				default: ;
			endcase
		endfunction

		// compare one accepted result with the oldest owed one
		function void check_result(input logic signed [WORD_W-1:0] w, input logic [1:0] s,
				input logic l);
			deque_result_t e;
			if (owed.size() == 0) begin
				mismatches++;
				if (mismatches <= 10)
					$display("mismatch at %0t: word %0d status %0d last %0d with none owed",
						$time, w, s, l);
				return;
			end
			e = owed.pop_front();
			if (w !== e.word || s !== e.status || l !== e.last) begin
				mismatches++;
				if (mismatches <= 10) begin
					$write("mismatch at %0t: expected word %0d status %0d last %0d, ",
						$time, e.word, e.status, e.last);
					$display("got word %0d status %0d last %0d", w, s, l);
				end
			end
		endfunction

		function int pending();
			return owed.size();
		endfunction
	endclass

	// clock and block ports, every input known from time zero
	logic                     clk = 1'b0;
	logic                     arst_n = 1'b0;
	logic                     req_valid = 1'b0;
	logic                     req_stall;
	logic [2:0]               req_type = '0;
	logic signed [WORD_W-1:0] value = '0;
	logic                     rsp_valid;
	logic                     rsp_stall = 1'b0;
	logic signed [WORD_W-1:0] word;
	logic [1:0]               status;
	logic                     last;

	// idling knobs for the current phase
	int idle_pct = 0;
	int stall_pct = 0;

	// each bump of hold_seq asks the receiver for one long hold-off
	int hold_seq = 0;
	int hold_seen = 0;
	int hold_left = 0;

	deque_shadow shadow = new();

	double_ended_queue u_dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.req_valid (req_valid),
		.req_stall (req_stall),
		.req_type  (req_type),
		.value     (value),
		.rsp_valid (rsp_valid),
		.rsp_stall (rsp_stall),
		.word      (word),
		.status    (status),
		.last      (last)
	);

	always #(CLK_PERIOD / 2) clk = ~clk;

	// receiver: random stall per cycle, or a counted hold-off when asked
	always @(posedge clk) begin
		if (hold_seq != hold_seen) begin
			hold_seen <= hold_seq;
			hold_left <= HOLD_CYCLES - 1;
			rsp_stall <= 1'b1;
		end else if (hold_left != 0) begin
			hold_left <= hold_left - 1;
			rsp_stall <= 1'b1;
		end else begin
			rsp_stall <= ($urandom_range(99) < stall_pct);
		end
	end

	// monitor: every request transfer feeds the shadow, every response transfer is checked
	always @(posedge clk) begin
		if (arst_n) begin
			if (req_valid && !req_stall)
				shadow.note_request(req_type, value);
			if (rsp_valid && !rsp_stall)
				shadow.check_result(word, status, last);
		end
	end

	function automatic logic signed [WORD_W-1:0] random_word();
		// lean on the extremes now and then
		if ($urandom_range(7) == 0) begin
			case ($urandom_range(3))
				0: return 32'sh7fff_ffff;
				1: return 32'sh8000_0000;
				2: return '0;
				default: return -1;
			endcase
		end
		return $urandom();
	endfunction

	// pick a request code, biased toward filling, draining or neither
	function automatic logic [2:0] pick_request(input mix_t mode);
		int r;
		int push_cut;
		int pop_cut;
		if ($urandom_range(99) < 4)
			return 3'($urandom_range(REQ_SPARE_A, REQ_SPARE_B));
		case (mode)
			MIX_FILL: begin
				push_cut = 65;
				pop_cut  = 85;
			end
			MIX_DRAIN: begin
				push_cut = 20;
				pop_cut  = 85;
			end
			default: begin
				push_cut = 40;
				pop_cut  = 80;
			end
		endcase
		r = $urandom_range(99);
		if (r < push_cut)
			return $urandom_range(1) ? REQ_PUSH_BACK : REQ_PUSH_FRONT;
		if (r < pop_cut)
			return $urandom_range(1) ? REQ_POP_BACK : REQ_POP_FRONT;
		return $urandom_range(1) ? REQ_DUMP_BWD : REQ_DUMP_FWD;
	endfunction

	// offer one request, with random idle cycles first; returns on the transfer edge
	task automatic send_item(input logic [2:0] kind, input logic signed [WORD_W-1:0] v);
		while ($urandom_range(99) < idle_pct) begin
			req_valid <= 1'b0;
			@(posedge clk);
		end
		req_valid <= 1'b1;
		req_type  <= kind;
		value     <= v;
		@(posedge clk);
		// payload holds while stalled
		while (req_stall)
			@(posedge clk);
	endtask

	// sender pauses until every owed result has been taken
	task automatic wait_for_results();
		req_valid <= 1'b0;
		@(posedge clk);
		while (shadow.pending() != 0)
			@(posedge clk);
	endtask

	// random requests in runs of one mix; spare codes do not count
	task automatic run_random(input int n_items);
		int done;
		int run;
		mix_t mode;
		logic [2:0] kind;
		done = 0;
		run = 0;
		mode = MIX_EVEN;
		while (done < n_items) begin
			if (run == 0) begin
				mode = mix_t'($urandom_range(2));
				run = 24;
			end
			kind = pick_request(mode);
			send_item(kind, random_word());
			if (kind <= REQ_DUMP_BWD) begin
				done++;
				run--;
			end
		end
	endtask

	// stimulus
	initial begin
		int idle_by_phase[4];
		int stall_by_phase[4];
		idle_by_phase  = '{0, 64, 0, 17};
		stall_by_phase = '{0, 0, 64, 17};

		repeat (RESET_TICKS) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed: empty cases and spare codes on an empty queue
		send_item(REQ_POP_FRONT, 32'sh1234_5678);
		send_item(REQ_DUMP_BWD, '0);
		send_item(REQ_SPARE_A, -1);
		send_item(REQ_SPARE_B, 32'sh7fff_ffff);
		// fill to the brim from both ends, extremes first
		send_item(REQ_PUSH_FRONT, 32'sh7fff_ffff);
		send_item(REQ_PUSH_BACK, 32'sh8000_0000);
		send_item(REQ_PUSH_FRONT, '0);
		send_item(REQ_PUSH_BACK, -1);
		for (int i = 0; i < DEPTH - 4; i++)
			send_item((i % 2) ? REQ_PUSH_BACK : REQ_PUSH_FRONT, $urandom());
		// push when full, both ends, is dropped
		send_item(REQ_PUSH_FRONT, 32'sh5555_5555);
		send_item(REQ_PUSH_BACK, 32'shaaaa_aaaa);
		// full read-outs both ways, then pops from both ends
		send_item(REQ_DUMP_FWD, '0);
		send_item(REQ_DUMP_BWD, '0);
		send_item(REQ_POP_FRONT, '0);
		send_item(REQ_POP_BACK, '0);
		wait_for_results();

		for (int p = 0; p < 4; p++) begin
			idle_pct = idle_by_phase[p];
			stall_pct <= stall_by_phase[p];
			if (p == 0) begin
				// receiver holds off while pushes keep coming, so the request side backs up
				hold_seq <= hold_seq + 1;
				for (int i = 0; i < BURST_ITEMS; i++)
					send_item($urandom_range(1) ? REQ_PUSH_BACK : REQ_PUSH_FRONT,
						random_word());
			end
			run_random(PHASE_ITEMS);
			wait_for_results();
		end

		// a last idle stretch before the verdict; any stray result counts as a mismatch
		repeat (TAIL_CYCLES) @(posedge clk);
		if (shadow.mismatches == 0 && shadow.pending() == 0)
			$display("double_ended_queue test passed");
		else
			$display("double_ended_queue test failed");
		$finish;
	end

	// watchdog
	initial begin
		#(CLK_PERIOD * 400000);
		$display("double_ended_queue test failed");
		$finish;
	end

endmodule
